>>> src/spectrum_bar_peak_hold_core_assert.svh
// Assertion macros for the spectrum bar peak-hold core checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SPECTRUM_BAR_PEAK_HOLD_CORE_ASSERT_SVH
`define SPECTRUM_BAR_PEAK_HOLD_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBPH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBPH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sbph_pkg.sv
// Shared types and constants for the spectrum bar peak-hold core.
// No dependencies; imported by the core and by its checker.
package sbph_pkg;

	localparam int BAND_W   = 6;
	localparam int LEVEL_W  = 16;
	localparam int HEIGHT_W = 16;
	localparam int OUT_W    = 10;
	localparam int SPEED_W  = 26;
	localparam int FRAC_W   = 6;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam int SBPH_NUM_BANDS_DEF = 64;

	localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
	localparam logic [SPEED_W-1:0] SPEED_START = SPEED_W'(655);
	localparam logic [14:0]        LOG10_2_Q16 = 15'd19728;

	localparam logic [15:0] SCALE_RST = 16'd256;
	localparam logic [9:0]  MAX_H_RST = 10'd63;
	localparam logic [15:0] DECAY_RST = 16'd90;
	localparam logic [15:0] ACCEL_RST = 16'd18350;

	typedef enum logic [1:0] {
		REG_HEIGHT_SCALE = 2'd0,
		REG_MAX_HEIGHT   = 2'd1,
		REG_BAR_DECAY    = 2'd2,
		REG_PEAK_ACCEL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] bar;
		logic [HEIGHT_W-1:0] peak;
		logic [SPEED_W-1:0]  speed;
	} band_state_t;

endpackage

>>> src/spectrum_bar_peak_hold_core.sv
// Spectrum bar peak-hold core: five-stage pipeline with per-band state memory.
// Depends on sbph_pkg.
// Throughput: one request per cycle; intake stalls only while the skid entry is full.
// Reset clears all control state and loads the register defaults; every band's
// bar, peak and fall speed then read as zero through per-band valid bits.
module spectrum_bar_peak_hold_core
	import sbph_pkg::*;
#(
	parameter int NUM_BANDS = SBPH_NUM_BANDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	// Request channel
	input  logic                band_valid,
	output logic                band_stall,
	input  logic [BAND_W-1:0]   band,
	input  logic [LEVEL_W-1:0]  band_level,
	// Result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [BAND_W-1:0]   band_out,
	output logic [OUT_W-1:0]    bar_level,
	output logic [OUT_W-1:0]    peak_level
);

	localparam int ADDR_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	// ------------------------------------------------------------------
	// Configuration registers. Writes must only happen while the pipe is idle
	// (the block does not enforce this), so the stages read them directly.
	// ------------------------------------------------------------------
	logic [15:0] scale_q;
	logic [9:0]  max_h_q;
	logic [15:0] decay_q;
	logic [15:0] accel_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			max_h_q <= MAX_H_RST;
			decay_q <= DECAY_RST;
			accel_q <= ACCEL_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_HEIGHT_SCALE: scale_q <= pwdata[15:0];
				REG_MAX_HEIGHT:   max_h_q <= pwdata[9:0];
				REG_BAR_DECAY:    decay_q <= pwdata[15:0];
				REG_PEAK_ACCEL:   accel_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_HEIGHT_SCALE: prdata = PDATA_W'(scale_q);
			REG_MAX_HEIGHT:   prdata = PDATA_W'(max_h_q);
			REG_BAR_DECAY:    prdata = PDATA_W'(decay_q);
			REG_PEAK_ACCEL:   prdata = PDATA_W'(accel_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control. Every stage moves together whenever the output skid
	// entry is empty; bubbles travel as cleared valid bits. Because the stall
	// is global, the request in the update stage always writes its band at
	// the same edge at which its successor reads the memory, so one forward
	// register covers every read-after-write hazard.
	// ------------------------------------------------------------------
	logic skid_vld_q;
	logic adv;
	logic accept;

	assign adv        = !skid_vld_q;
	assign band_stall = skid_vld_q;
	assign accept     = band_valid && !band_stall;

	// ------------------------------------------------------------------
	// Stage 1: find the leading one of the magnitude and left-align the
	// bits below it into a Q0.16 mantissa fraction.
	// ------------------------------------------------------------------
	logic [2:0]  lead;
	logic [3:0]  lshift;
	logic [31:0] frac_wide;
	logic        low_mag;

	always_comb begin
		lead = '0;
		for (int i = 8; i < LEVEL_W; i++) begin
			if (band_level[i]) begin
				lead = 3'(i - 8);
			end
		end
	end

	assign low_mag   = (band_level[15:8] == 8'd0);
	assign lshift    = 4'd8 - {1'b0, lead};
	assign frac_wide = {16'd0, band_level} << lshift;

	logic              v_s1;
	logic [BAND_W-1:0] band_s1;
	logic              low_mag_s1;
	logic [2:0]        lead_s1;
	logic [15:0]       frac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			band_s1    <= band;
			low_mag_s1 <= low_mag;
			lead_s1    <= lead;
			frac_s1    <= frac_wide[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: curvature term f*(1-f) of the log2 approximation.
	// ------------------------------------------------------------------
	logic [32:0] curv_prod;

	assign curv_prod = 33'(frac_s1) * 33'(17'h10000 - 17'(frac_s1));

	logic              v_s2;
	logic [BAND_W-1:0] band_s2;
	logic              low_mag_s2;
	logic [18:0]       base_s2;
	logic [15:0]       curv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			band_s2    <= band_s1;
			low_mag_s2 <= low_mag_s1;
			base_s2    <= {lead_s1, frac_s1};
			curv_s2    <= curv_prod[31:16];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: finish log2 in Q.16 and scale it to log10.
	// ------------------------------------------------------------------
	logic [19:0] corr;
	logic [19:0] log2v;
	logic [34:0] lg_prod;

	assign corr    = (20'(curv_s2) * 20'd11) >> 5;
	assign log2v   = 20'(base_s2) + corr;
	assign lg_prod = 35'(log2v) * 35'(LOG10_2_Q16);

	logic              v_s3;
	logic [BAND_W-1:0] band_s3;
	logic              low_mag_s3;
	logic [18:0]       lg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			band_s3    <= band_s2;
			low_mag_s3 <= low_mag_s2;
			lg_s3      <= lg_prod[34:16];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 entry: apply the gain, clamp to the maximum height, and read
	// the band's state from memory. The memory read data is registered
	// together with the stage.
	// ------------------------------------------------------------------
	logic [34:0]         h_prod;
	logic [15:0]         h_raw;
	logic [HEIGHT_W-1:0] h_lim;
	logic [HEIGHT_W-1:0] h_tgt;
	logic [ADDR_W-1:0]   rd_addr;

	assign h_prod  = 35'(lg_s3) * 35'(scale_q);
	assign h_raw   = h_prod[34:19];
	assign h_lim   = {max_h_q, 6'd0};
	assign h_tgt   = low_mag_s3 ? '0 : ((h_raw > h_lim) ? h_lim : h_raw);
	assign rd_addr = ADDR_W'(band_s3);

	band_state_t             state_mem [NUM_BANDS];
	logic [NUM_BANDS-1:0]    ent_vld_q;

	logic              v_s4;
	logic [BAND_W-1:0] band_s4;
	logic [HEIGHT_W-1:0] h_s4;
	logic              inr_s4;
	band_state_t       rd_s4;
	logic              rdv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			band_s4 <= band_s3;
			h_s4    <= h_tgt;
			inr_s4  <= ({3'd0, band_s3} < 9'(NUM_BANDS));
			rd_s4   <= state_mem[rd_addr];
			rdv_s4  <= ent_vld_q[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: bar and peak update.
	// ------------------------------------------------------------------
	logic              fwd_vld_q;
	logic [BAND_W-1:0] fwd_band_q;
	band_state_t       fwd_q;

	band_state_t        cur;
	band_state_t        nxt;
	logic [SPEED_W-1:0] pk_shift;
	logic [SPEED_W-1:0] pk_diff;
	logic [HEIGHT_W-1:0] pk_fall;
	logic [41:0]        spd_prod;
	logic [27:0]        spd_acc;
	logic [SPEED_W-1:0] spd_next;
	logic               bar_up;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;

	always_comb begin
		if (fwd_vld_q && (fwd_band_q == band_s4)) begin
			cur = fwd_q;
		end else if (rdv_s4) begin
			cur = rd_s4;
		end else begin
			cur = '0;
		end
	end

	assign pk_shift = {cur.peak, 10'd0};
	assign pk_diff  = pk_shift - cur.speed;
	assign pk_fall  = (pk_shift > cur.speed) ? pk_diff[25:10] : '0;
	assign spd_prod = 42'(cur.speed) * 42'(accel_q);
	assign spd_acc  = spd_prod[41:14];
	assign spd_next = (spd_acc > 28'(SPEED_MAX)) ? SPEED_MAX : spd_acc[SPEED_W-1:0];
	assign bar_up   = (h_s4 > cur.bar);

	always_comb begin
		nxt = cur;
		if (bar_up) begin
			nxt.bar = h_s4;
		end else if (cur.bar > decay_q) begin
			nxt.bar = cur.bar - decay_q;
		end else begin
			nxt.bar = '0;
		end
		// A new peak restarts the slow fall; otherwise a nonzero peak drops
		// by its speed, never below the bar.
		if (bar_up && (h_s4 > cur.peak)) begin
			nxt.peak  = h_s4;
			nxt.speed = SPEED_START;
		end else if (cur.peak != '0) begin
			nxt.speed = spd_next;
			nxt.peak  = (pk_fall < nxt.bar) ? nxt.bar : pk_fall;
		end
	end

	assign wr_en   = adv && v_s4 && inr_s4;
	assign wr_addr = ADDR_W'(band_s4);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			state_mem[wr_addr] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			fwd_vld_q <= v_s4 && inr_s4;
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_band_q <= band_s4;
			fwd_q      <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// Output register with one skid entry. A finished result goes straight
	// to the output when it is free or being taken; otherwise it parks in
	// the skid entry, which holds the pipeline until the output drains.
	// ------------------------------------------------------------------
	logic [OUT_W-1:0] res_bar;
	logic [OUT_W-1:0] res_peak;
	logic             out_take;

	assign res_bar  = inr_s4 ? nxt.bar[HEIGHT_W-1:FRAC_W]  : '0;
	assign res_peak = inr_s4 ? nxt.peak[HEIGHT_W-1:FRAC_W] : '0;
	assign out_take = result_valid && !result_stall;

	logic              out_vld_q;
	logic [BAND_W-1:0] out_band_q;
	logic [OUT_W-1:0]  out_bar_q;
	logic [OUT_W-1:0]  out_peak_q;
	logic [BAND_W-1:0] skid_band_q;
	logic [OUT_W-1:0]  skid_bar_q;
	logic [OUT_W-1:0]  skid_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (v_s4) begin
			if (out_vld_q && !out_take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_band_q <= skid_band_q;
				out_bar_q  <= skid_bar_q;
				out_peak_q <= skid_peak_q;
			end
		end else if (v_s4) begin
			if (out_vld_q && !out_take) begin
				skid_band_q <= band_s4;
				skid_bar_q  <= res_bar;
				skid_peak_q <= res_peak;
			end else begin
				out_band_q <= band_s4;
				out_bar_q  <= res_bar;
				out_peak_q <= res_peak;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign band_out     = out_band_q;
	assign bar_level    = out_bar_q;
	assign peak_level   = out_peak_q;

endmodule

>>> src/sbph_checker.sv
// Port-level checker for the spectrum bar peak-hold core, bound to the top level.
// Depends on sbph_pkg and spectrum_bar_peak_hold_core_assert.svh.
`include "spectrum_bar_peak_hold_core_assert.svh"

module sbph_checker
	import sbph_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              band_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic [BAND_W-1:0] band_out,
	input logic [OUT_W-1:0]  bar_level,
	input logic [OUT_W-1:0]  peak_level
);

	// A stalled result keeps its contents.
	`SBPH_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(band_out) && $stable(bar_level) && $stable(peak_level),
		"stalled result changed")

	// Intake only stalls while a finished result waits at the output.
	`SBPH_ASSERT_SAME(a_stall_needs_result, band_stall, result_valid,
		"request stall without a pending result")

	// The request stall only rises after a result sat stalled.
	`SBPH_ASSERT_SAME(a_stall_cause, $rose(band_stall), $past(result_valid && result_stall),
		"request stall rose without output back-pressure")

	// The peak hold never sits below the bar.
	`SBPH_ASSERT_SAME(a_peak_above_bar, result_valid, peak_level >= bar_level, "peak below bar")

endmodule

bind spectrum_bar_peak_hold_core sbph_checker u_sbph_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.band_stall   (band_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.band_out     (band_out),
	.bar_level    (bar_level),
	.peak_level   (peak_level)
);
